// File: rtl/mvfb_pkg.sv
// Shared types, constants and the CRC step for the MAVLink v1 frame builder.
// No dependencies; used by the top level.
`default_nettype none

package mvfb_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_START_MARKER   = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd1;
    localparam logic [1:0] REG_MESSAGE_ID     = 2'd2;
    localparam logic [1:0] REG_CRC_EXTRA      = 2'd3;

    // Register reset values
    localparam logic [7:0] START_MARKER_RST   = 8'd254;
    localparam logic [7:0] PAYLOAD_LENGTH_RST = 8'd32;
    localparam logic [7:0] MESSAGE_ID_RST     = 8'd0;
    localparam logic [7:0] CRC_EXTRA_RST      = 8'd0;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    // Emit phase codes, one per byte slot of a frame
    localparam int PHASE_W = 4;
    localparam logic [PHASE_W-1:0] PH_MARKER = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LENGTH = 4'd1;
    localparam logic [PHASE_W-1:0] PH_SEQ    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_SYS    = 4'd3;
    localparam logic [PHASE_W-1:0] PH_COMP   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_MSGID  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_PAY    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_CRC_LO = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CRC_HI = 4'd8;

    // One accepted item, held while its bytes go out
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] sender_sys;
        logic [7:0] sender_comp;
        logic [7:0] seq;
        logic       last;
    } item_t;

    // One byte step of CRC-16/MCRF4XX
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/mavlink_v1_frame_builder.sv
// MAVLink v1 frame builder: header, payload pass-through and CRC-16 trailer.
// Depends on mvfb_pkg (register codes, phase codes, item_t, crc_feed).
//
//  channel  | signals                                           | moves
//  ---------+---------------------------------------------------+----------------------
//  item     | item_valid, item_stall, payload_byte, sender_sys, | one payload byte
//           | sender_comp, channel                              |
//  result   | result_valid, result_stall, out_byte, frame_end,  | one framed byte
//           | run_end                                           |
//  config   | cfg_write, cfg_index, cfg_data                    | one register write
//
// One result byte per cycle from the output register while result_stall is low;
// an item yields 1 to 9 bytes (1 in mid-payload, up to 9).
// A new item is taken in the cycle its predecessor's last byte moves to the output.
// rst_n resets config, sequence counters, payload count, valids and CRC at once.
// A stalled result holds its byte; the item side stalls only while bytes wait.
`default_nettype none

module mavlink_v1_frame_builder #(
    parameter int CHANNELS = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // item channel
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [7:0] payload_byte,
    input  wire logic [7:0] sender_sys,
    input  wire logic [7:0] sender_comp,
    input  wire logic [1:0] channel,
    // result channel
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      out_byte,
    output logic            frame_end,
    output logic            run_end,
    // configuration
    input  wire logic       cfg_write,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration registers
    logic [7:0] start_marker_reg;
    logic [7:0] payload_length_reg;
    logic [7:0] message_id_reg;
    logic [7:0] crc_extra_reg;

    // frame state
    logic [7:0]  seq_reg [CHANNELS];
    logic [7:0]  payload_count_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    // item buffer
    logic                           buf_valid_reg;
    mvfb_pkg::item_t                buf_reg;
    mvfb_pkg::item_t                buf_next;
    logic [mvfb_pkg::PHASE_W-1:0]   phase_reg;
    logic [mvfb_pkg::PHASE_W-1:0]   end_phase;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       frame_end_reg;
    logic       frame_end_next;
    logic       run_end_reg;

    // handshake and decode
    logic            emit;
    logic            buf_done;
    logic            accept;
    logic            first;
    logic [7:0]      count_inc;
    logic [CH_W-1:0] ch_idx;
    logic [4:0]      ch_wide;
    logic [7:0]      feed_byte;
    logic [15:0]     crc_fed;

    // ---------------- handshake ----------------
    assign end_phase  = buf_reg.last ? mvfb_pkg::PH_CRC_HI : mvfb_pkg::PH_PAY;
    assign emit       = buf_valid_reg && (!out_valid_reg || !result_stall);
    assign buf_done   = emit && (phase_reg == end_phase);
    assign item_stall = buf_valid_reg && !buf_done;
    assign accept     = item_valid && !item_stall;

    // ---------------- item decode at accept ----------------
    assign first     = (payload_count_reg == 8'd0);
    assign count_inc = payload_count_reg + 8'd1;

    // channel folded onto the counters; a 2-bit channel needs one subtract at most
    always_comb
    begin
        ch_wide = {3'b000, channel};
        if (CHANNELS == 1)
        begin
            ch_wide = 5'd0;
        end
        else if (ch_wide >= 5'(CHANNELS))
        begin
            ch_wide = ch_wide - 5'(CHANNELS);
        end
    end

    assign ch_idx = ch_wide[CH_W-1:0];

    always_comb
    begin
        buf_next.payload_byte = payload_byte;
        buf_next.sender_sys   = sender_sys;
        buf_next.sender_comp  = sender_comp;
        buf_next.seq          = seq_reg[ch_idx];
        buf_next.last         = (count_inc >= payload_length_reg);
    end

    // ---------------- byte select and CRC ----------------
    always_comb
    begin
        unique case (phase_reg)
            mvfb_pkg::PH_LENGTH: feed_byte = payload_length_reg;
            mvfb_pkg::PH_SEQ:    feed_byte = buf_reg.seq;
            mvfb_pkg::PH_SYS:    feed_byte = buf_reg.sender_sys;
            mvfb_pkg::PH_COMP:   feed_byte = buf_reg.sender_comp;
            mvfb_pkg::PH_MSGID:  feed_byte = message_id_reg;
            mvfb_pkg::PH_PAY:    feed_byte = buf_reg.payload_byte;
            mvfb_pkg::PH_CRC_LO: feed_byte = crc_extra_reg;
            default:             feed_byte = 8'h00;
        endcase
    end

    assign crc_fed = mvfb_pkg::crc_feed(crc_reg, feed_byte);

    always_comb
    begin
        frame_end_next = 1'b0;
        unique case (phase_reg)
            mvfb_pkg::PH_MARKER:
            begin
                out_byte_next = start_marker_reg;
                crc_next      = mvfb_pkg::CRC_SEED;
            end
            mvfb_pkg::PH_CRC_LO:
            begin
                out_byte_next = crc_fed[7:0];
                crc_next      = crc_fed;
            end
            mvfb_pkg::PH_CRC_HI:
            begin
                out_byte_next  = crc_reg[15:8];
                crc_next       = mvfb_pkg::CRC_SEED;
                frame_end_next = 1'b1;
            end
            mvfb_pkg::PH_LENGTH, mvfb_pkg::PH_SEQ, mvfb_pkg::PH_SYS,
            mvfb_pkg::PH_COMP, mvfb_pkg::PH_MSGID, mvfb_pkg::PH_PAY:
            begin
                out_byte_next = feed_byte;
                crc_next      = crc_fed;
            end
            default:
            begin
                out_byte_next = 8'h00;
                crc_next      = crc_reg;
            end
        endcase
    end

    // ---------------- configuration registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg   <= mvfb_pkg::START_MARKER_RST;
            payload_length_reg <= mvfb_pkg::PAYLOAD_LENGTH_RST;
            message_id_reg     <= mvfb_pkg::MESSAGE_ID_RST;
            crc_extra_reg      <= mvfb_pkg::CRC_EXTRA_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mvfb_pkg::REG_START_MARKER:   start_marker_reg   <= cfg_data;
                mvfb_pkg::REG_PAYLOAD_LENGTH: payload_length_reg <= cfg_data;
                mvfb_pkg::REG_MESSAGE_ID:     message_id_reg     <= cfg_data;
                mvfb_pkg::REG_CRC_EXTRA:      crc_extra_reg      <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // ---------------- frame state: sequences and payload count ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                seq_reg[i] <= 8'd0;
            end
            payload_count_reg <= 8'd0;
        end
        else if (accept)
        begin
            if (first)
            begin
                seq_reg[ch_idx] <= seq_reg[ch_idx] + 8'd1;
            end
            payload_count_reg <= buf_next.last ? 8'd0 : count_inc;
        end
    end

    // ---------------- buffer control, CRC, output valid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            phase_reg     <= mvfb_pkg::PH_MARKER;
            crc_reg       <= mvfb_pkg::CRC_SEED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                crc_reg <= crc_next;
            end
            if (accept)
            begin
                buf_valid_reg <= 1'b1;
                phase_reg     <= first ? mvfb_pkg::PH_MARKER : mvfb_pkg::PH_PAY;
            end
            else if (buf_done)
            begin
                buf_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                phase_reg <= phase_reg + 4'd1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            buf_reg <= buf_next;
        end
        if (emit)
        begin
            out_byte_reg  <= out_byte_next;
            frame_end_reg <= frame_end_next;
            run_end_reg   <= (phase_reg == end_phase);
        end
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign frame_end    = frame_end_reg;
    assign run_end      = run_end_reg;

endmodule

`default_nettype wire

// File: rtl/mvfb_checker.sv
// Port-level checker for the MAVLink v1 frame builder, with its bind.
// No package dependency; sees only the top-level ports.
`default_nettype none

module mvfb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] out_byte,
    input wire logic       frame_end,
    input wire logic       run_end
);

    // a stalled result transfer holds its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_byte))
    else $error("stalled result byte changed");

    // the CRC high byte always closes the bytes of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_end |-> run_end)
    else $error("frame end without run end");

    // while an item still has bytes behind a stalled one, no new item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !run_end && result_stall |-> item_stall)
    else $error("item taken while bytes of the previous item wait");

    // an accepted item is followed by a valid result byte
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |-> ##2 result_valid)
    else $error("accepted item produced no result");

endmodule

bind mavlink_v1_frame_builder mvfb_checker u_mvfb_checker (.*);

`default_nettype wire
